// ===== rtl/cvpc_pkg.sv =====
// Shared constants, types and the calibration point table for the charge
// voltage calibration block. Used by the channel interfaces, the divider and the top level.
// Depends on nothing.
package cvpc_pkg;

   // Table size and stored calibration points
   localparam int TABLE_POINTS  = 28;
   localparam int STORED_POINTS = 28;

   // Field and register widths
   localparam int MV_W       = 16;
   localparam int STATUS_W   = 2;
   localparam int START_W    = 16;
   localparam int STEP_W     = 12;
   localparam int MARGIN_W   = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [15:0] CAL_POINTS [STORED_POINTS] = '{
      16'd3034,  16'd4021,  16'd4877,  16'd5696,  16'd6798,  16'd7867,  16'd8956,
      16'd10074, 16'd11163, 16'd12220, 16'd13275, 16'd14372, 16'd15430, 16'd16508,
      16'd17597, 16'd18649, 16'd19726, 16'd20792, 16'd21860, 16'd22922, 16'd23992,
      16'd25086, 16'd26110, 16'd27228, 16'd28252, 16'd29328, 16'd30377, 16'd31456
   };

   // Points past the stored ones continue at the spacing of the last segment
   localparam int LAST_GAP     = int'(CAL_POINTS[STORED_POINTS-1]) -
                                 int'(CAL_POINTS[STORED_POINTS-2]);
   localparam int EXTRA_POINTS = (TABLE_POINTS > STORED_POINTS) ?
                                 (TABLE_POINTS - STORED_POINTS) : 0;
   localparam int PT_LAST      = int'(CAL_POINTS[STORED_POINTS-1]) + EXTRA_POINTS * LAST_GAP;

   localparam int IDX_W  = $clog2(TABLE_POINTS);
   localparam int PT_W   = $clog2(PT_LAST + 1);
   localparam int SUM_W  = ((PT_W > MV_W) ? PT_W : MV_W) + 1;
   // Widest segment is below 2^11; offset into a segment stays below gap + margin
   localparam int DEN_W  = 11;
   localparam int MAG_W  = 13;
   localparam int PROD_W = STEP_W + MAG_W;
   localparam int CNT_W  = $clog2(PROD_W);
   localparam int BASE_W = STEP_W + IDX_W + 1;
   localparam int RES_W  = PROD_W + 2;

   // Register reset values
   localparam logic [START_W-1:0]  START_RESET  = START_W'(4000);
   localparam logic [STEP_W-1:0]   STEP_RESET   = STEP_W'(1000);
   localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(500);

   localparam logic [MV_W-1:0] MV_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_VOLTAGE = 2'd0,
      CSR_STEP          = 2'd1,
      CSR_MARGIN        = 2'd2
   } csr_index_type;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_LOW  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_HIGH = 2'd2;

   typedef struct packed {
      logic done;
      logic rem_nz;
   } div_stat_type;

   function automatic logic [PT_W-1:0] point_at(input logic [IDX_W-1:0] idx);
      logic [PT_W-1:0] pt;
      if (int'(idx) < STORED_POINTS) begin
         pt = PT_W'(CAL_POINTS[idx]);
      end else begin
         pt = PT_W'(int'(CAL_POINTS[STORED_POINTS-1]) +
                    (int'(idx) - (STORED_POINTS - 1)) * LAST_GAP);
      end
      return pt;
   endfunction

endpackage

// ===== rtl/cvpc_if.sv =====
// Valid/ready channel interfaces for the charge voltage calibration block.
// Depends on cvpc_pkg for field widths.
interface cvpc_req_if;
   logic                        valid;
   logic                        ready;
   logic [cvpc_pkg::MV_W-1:0]   measured_mv;

   modport source (output valid, output measured_mv, input ready);
   modport sink   (input valid, input measured_mv, output ready);
endinterface

interface cvpc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cvpc_pkg::MV_W-1:0]     adjusted_mv;
   logic [cvpc_pkg::STATUS_W-1:0] status;

   modport source (output valid, output adjusted_mv, output status, input ready);
   modport sink   (input valid, input adjusted_mv, input status, output ready);
endinterface

// ===== rtl/cvpc_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on cvpc_pkg for widths and the status struct.
module cvpc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [cvpc_pkg::PROD_W-1:0]   dividend,
   input  logic [cvpc_pkg::DEN_W-1:0]    divisor,
   output logic [cvpc_pkg::PROD_W-1:0]   quotient,
   output cvpc_pkg::div_stat_type        stat
);

   logic [cvpc_pkg::PROD_W-1:0] num_ff, num_in;
   logic [cvpc_pkg::DEN_W-1:0]  rem_ff, rem_in;
   logic [cvpc_pkg::DEN_W-1:0]  den_ff, den_in;
   logic [cvpc_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;

   logic [cvpc_pkg::DEN_W:0]    rem_shift;
   logic                        fits;

   // Bring down the next dividend bit and try a subtract
   assign rem_shift = {rem_ff, num_ff[cvpc_pkg::PROD_W-1]};
   assign fits      = rem_shift >= {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = cvpc_pkg::CNT_W'(cvpc_pkg::PROD_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[cvpc_pkg::PROD_W-2:0], fits};
         rem_in = fits ? cvpc_pkg::DEN_W'(rem_shift - {1'b0, den_ff})
                       : cvpc_pkg::DEN_W'(rem_shift);
         cnt_in = cnt_ff - cvpc_pkg::CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign quotient    = num_ff;
   assign stat.done   = done_ff;
   assign stat.rem_nz = |rem_ff;

endmodule

// ===== rtl/charge_voltage_pwl_calibration_top.sv =====
// Top level of the charge voltage calibration block: piecewise linear
// correction of a raw reading against the calibration point table.
// Depends on cvpc_pkg, cvpc_if (channel interfaces) and cvpc_div.
//
//   Channel  Direction  Handshake          Payload
//   req_if   in         valid/ready        measured_mv[15:0]
//   rsp_if   out        valid/ready        adjusted_mv[15:0], status[1:0]
//   csr_*    in         csr_we only        csr_index[1:0], csr_wdata[15:0]
//
// An in-range reading passes through one range check, a serial segment search over
// TABLE_POINTS-2 table points taken in turn, a difference step, a product step that loads
// the divider, the divide (25 quotient bits and a check for done) and a final step that
// loads the output register. A reading out of range goes from the range check straight
// to the output register step. The next request transfer is taken only after the
// previous item has been loaded into the output register.
// Reset is synchronous and active high; it restores the register defaults and empties the
// result register. A stalled result sits in the output register; a new request
// transfer is taken while it waits, and processing holds at the last step
// until the output register frees.
module charge_voltage_pwl_calibration_top (
   input  logic                              clock,
   input  logic                              reset,
   cvpc_req_if.sink                          req_if,
   cvpc_rsp_if.source                        rsp_if,
   input  logic                              csr_we,
   input  logic [cvpc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cvpc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SEARCH,
      ST_DIFF,
      ST_PROD,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   state_type                          state_ff, state_in;

   // Configuration registers
   logic [cvpc_pkg::START_W-1:0]       start_ff, start_in;
   logic [cvpc_pkg::STEP_W-1:0]        step_ff, step_in;
   logic [cvpc_pkg::MARGIN_W-1:0]      margin_ff, margin_in;

   // Working registers for one item
   logic [cvpc_pkg::MV_W-1:0]          reading_ff, reading_in;
   logic [cvpc_pkg::IDX_W-1:0]         k_ff, k_in;
   logic [cvpc_pkg::IDX_W-1:0]         idx_ff, idx_in;
   logic                               neg_ff, neg_in;
   logic [cvpc_pkg::MAG_W-1:0]         mag_ff, mag_in;
   logic [cvpc_pkg::DEN_W-1:0]         den_ff, den_in;
   logic [cvpc_pkg::BASE_W-1:0]        base_ff, base_in;
   logic [cvpc_pkg::STATUS_W-1:0]      item_status_ff, item_status_in;

   // Output register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [cvpc_pkg::MV_W-1:0]          rsp_adj_ff, rsp_adj_in;
   logic [cvpc_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;

   // Table lookups
   logic [cvpc_pkg::PT_W-1:0]          first_pt, last_pt, search_pt, lo_pt, hi_pt;
   logic                               too_low, too_high;
   logic [cvpc_pkg::SUM_W-1:0]         rd_ext, lo_ext;

   // Divider hookup
   logic                               div_start;
   logic [cvpc_pkg::PROD_W-1:0]        div_dividend;
   logic [cvpc_pkg::PROD_W-1:0]        div_quotient;
   cvpc_pkg::div_stat_type             div_stat;

   // Final sum
   logic [cvpc_pkg::RES_W-1:0]         q_mag;
   logic signed [cvpc_pkg::RES_W-1:0]  q_signed;
   logic signed [cvpc_pkg::RES_W-1:0]  res_sum;
   logic [cvpc_pkg::MV_W-1:0]          res_sat;
   logic                               out_free;

   assign first_pt  = cvpc_pkg::point_at('0);
   assign last_pt   = cvpc_pkg::point_at(cvpc_pkg::IDX_W'(cvpc_pkg::TABLE_POINTS - 1));
   assign search_pt = cvpc_pkg::point_at(idx_ff);
   assign lo_pt     = cvpc_pkg::point_at(k_ff);
   assign hi_pt     = cvpc_pkg::point_at(k_ff + cvpc_pkg::IDX_W'(1));

   assign rd_ext   = cvpc_pkg::SUM_W'(reading_ff);
   assign lo_ext   = cvpc_pkg::SUM_W'(lo_pt);
   assign too_low  = (rd_ext + cvpc_pkg::SUM_W'(margin_ff)) < cvpc_pkg::SUM_W'(first_pt);
   assign too_high = rd_ext > (cvpc_pkg::SUM_W'(last_pt) + cvpc_pkg::SUM_W'(margin_ff));

   // The multiply result lands straight in the divider's shift register
   assign div_start    = (state_ff == ST_PROD);
   assign div_dividend = cvpc_pkg::PROD_W'(step_ff) * cvpc_pkg::PROD_W'(mag_ff);

   cvpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (den_ff),
      .quotient (div_quotient),
      .stat     (div_stat)
   );

   // Floor toward minus infinity: a negative offset with a remainder rounds down
   assign q_mag    = cvpc_pkg::RES_W'(div_quotient) +
                     cvpc_pkg::RES_W'(neg_ff && div_stat.rem_nz);
   assign q_signed = neg_ff ? -signed'(q_mag) : signed'(q_mag);
   assign res_sum  = signed'(cvpc_pkg::RES_W'(base_ff)) + q_signed;

   always_comb begin
      if (res_sum < 0) begin
         res_sat = '0;
      end else if (res_sum > signed'(cvpc_pkg::RES_W'(cvpc_pkg::MV_MAX))) begin
         res_sat = cvpc_pkg::MV_MAX;
      end else begin
         res_sat = res_sum[cvpc_pkg::MV_W-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      state_in       = state_ff;
      start_in       = start_ff;
      step_in        = step_ff;
      margin_in      = margin_ff;
      reading_in     = reading_ff;
      k_in           = k_ff;
      idx_in         = idx_ff;
      neg_in         = neg_ff;
      mag_in         = mag_ff;
      den_in         = den_ff;
      base_in        = base_ff;
      item_status_in = item_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_adj_in     = rsp_adj_ff;
      rsp_status_in  = rsp_status_ff;

      // Drop the result once the sink takes it
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         unique case (csr_index)
            cvpc_pkg::CSR_START_VOLTAGE: start_in = csr_wdata[cvpc_pkg::START_W-1:0];
            cvpc_pkg::CSR_STEP:          step_in  = csr_wdata[cvpc_pkg::STEP_W-1:0];
            cvpc_pkg::CSR_MARGIN:        margin_in = csr_wdata[cvpc_pkg::MARGIN_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               reading_in = req_if.measured_mv;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            k_in   = '0;
            idx_in = cvpc_pkg::IDX_W'(1);
            if (too_low) begin
               item_status_in = cvpc_pkg::STATUS_LOW;
               state_in       = ST_DONE;
            end else if (too_high) begin
               item_status_in = cvpc_pkg::STATUS_HIGH;
               state_in       = ST_DONE;
            end else begin
               item_status_in = cvpc_pkg::STATUS_OK;
               state_in       = (cvpc_pkg::TABLE_POINTS > 2) ? ST_SEARCH : ST_DIFF;
            end
         end
         ST_SEARCH: begin
            // Track the last point not above the reading
            if (cvpc_pkg::SUM_W'(search_pt) <= rd_ext) begin
               k_in = idx_ff;
            end
            if (idx_ff == cvpc_pkg::IDX_W'(cvpc_pkg::TABLE_POINTS - 2)) begin
               state_in = ST_DIFF;
            end else begin
               idx_in = idx_ff + cvpc_pkg::IDX_W'(1);
            end
         end
         ST_DIFF: begin
            neg_in   = rd_ext < lo_ext;
            mag_in   = (rd_ext < lo_ext) ? cvpc_pkg::MAG_W'(lo_ext - rd_ext)
                                         : cvpc_pkg::MAG_W'(rd_ext - lo_ext);
            den_in   = cvpc_pkg::DEN_W'(hi_pt - lo_pt);
            state_in = ST_PROD;
         end
         ST_PROD: begin
            base_in  = cvpc_pkg::BASE_W'(start_ff) +
                       cvpc_pkg::BASE_W'(k_ff) * cvpc_pkg::BASE_W'(step_ff);
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold until the output register frees
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = item_status_ff;
               rsp_adj_in    = (item_status_ff == cvpc_pkg::STATUS_OK) ? res_sat : '0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= cvpc_pkg::START_RESET;
         step_ff      <= cvpc_pkg::STEP_RESET;
         margin_ff    <= cvpc_pkg::MARGIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         step_ff      <= step_in;
         margin_ff    <= margin_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      reading_ff     <= reading_in;
      k_ff           <= k_in;
      idx_ff         <= idx_in;
      neg_ff         <= neg_in;
      mag_ff         <= mag_in;
      den_ff         <= den_in;
      base_ff        <= base_in;
      item_status_ff <= item_status_in;
      rsp_adj_ff     <= rsp_adj_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.adjusted_mv = rsp_adj_ff;
   assign rsp_if.status      = rsp_status_ff;

   // A rejected reading never carries a voltage
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != cvpc_pkg::STATUS_OK) |-> (rsp_adj_ff == '0))
      else $error("rejected result carries nonzero voltage");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_status_ff == cvpc_pkg::STATUS_OK ||
                        rsp_status_ff == cvpc_pkg::STATUS_LOW ||
                        rsp_status_ff == cvpc_pkg::STATUS_HIGH))
      else $error("result status out of range");

   a_segment_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIFF || state_ff == ST_PROD || state_ff == ST_DIVIDE) |->
      (k_ff <= cvpc_pkg::IDX_W'(cvpc_pkg::TABLE_POINTS - 2)))
      else $error("segment index past the last segment");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide step");

   a_ok_after_divide: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && $past(state_ff) == ST_DIVIDE) |->
      (item_status_ff == cvpc_pkg::STATUS_OK))
      else $error("divided item flagged out of range");

endmodule
